// File: sv/hfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfd_pkg
// Types and constants shared by the HTTP/2 frame deframer modules.
// ----------------------------------------------------------------------------
package hfd_pkg;

  localparam logic [7:0] T_DATA     = 8'd0;
  localparam logic [7:0] T_HEADERS  = 8'd1;
  localparam logic [7:0] T_PRIORITY = 8'd2;
  localparam logic [7:0] T_RST      = 8'd3;
  localparam logic [7:0] T_SETTINGS = 8'd4;
  localparam logic [7:0] T_PUSH     = 8'd5;
  localparam logic [7:0] T_PING     = 8'd6;
  localparam logic [7:0] T_GOAWAY   = 8'd7;
  localparam logic [7:0] T_WINUPD   = 8'd8;

  localparam int F_ACK_BIT    = 0;
  localparam int F_PADDED_BIT = 3;
  localparam int F_PRIO_BIT   = 5;

  localparam logic [2:0] V_OK    = 3'd0;
  localparam logic [2:0] V_LEN   = 3'd1;
  localparam logic [2:0] V_PAD   = 3'd2;
  localparam logic [2:0] V_SHORT = 3'd3;
  localparam logic [2:0] V_TRUNC = 3'd4;

  localparam logic [3:0] HP_LEN_HI  = 4'd0;
  localparam logic [3:0] HP_LEN_MID = 4'd1;
  localparam logic [3:0] HP_LEN_LO  = 4'd2;
  localparam logic [3:0] HP_TYPE    = 4'd3;
  localparam logic [3:0] HP_FLAGS   = 4'd4;
  localparam logic [3:0] HP_SID3    = 4'd5;
  localparam logic [3:0] HP_SID2    = 4'd6;
  localparam logic [3:0] HP_SID1    = 4'd7;
  localparam logic [3:0] HP_LAST    = 4'd8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_data;
  } hfd_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [30:0] stream_id;
    logic [23:0] payload_length;
    logic [2:0]  verdict;
  } hfd_out_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] hdr_pos;
    logic       payload;
    logic       first;
    logic       last;
    logic       trunc;
  } hfd_tag_t;

endpackage
`default_nettype wire

// File: sv/hfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfd_front
// Tracks header position and payload count; tags each accepted byte.
// ----------------------------------------------------------------------------
module hfd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire hfd_pkg::hfd_in_t in_word,
  output hfd_pkg::hfd_tag_t     tag
);

  logic [3:0]  pos_r, pos_nxt;
  logic        pay_r, pay_nxt;
  logic [23:0] len_r, len_nxt;
  logic [23:0] cnt_r, cnt_nxt;
  logic [23:0] cnt_inc;

  always_comb begin
    pos_nxt     = pos_r;
    pay_nxt     = pay_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    cnt_inc     = cnt_r + 24'd1;
    tag.data    = in_word.in_byte;
    tag.hdr_pos = pos_r;
    tag.payload = pay_r;
    tag.first   = (cnt_r == 24'd0);
    tag.last    = 1'b0;
    tag.trunc   = 1'b0;
    if (!pay_r) begin
      unique case (pos_r)
        hfd_pkg::HP_LEN_HI:  len_nxt = {in_word.in_byte, 16'h0000};
        hfd_pkg::HP_LEN_MID: len_nxt[15:8] = in_word.in_byte;
        hfd_pkg::HP_LEN_LO:  len_nxt[7:0] = in_word.in_byte;
        default: ;
      endcase
      if (pos_r == hfd_pkg::HP_LAST) begin
        pos_nxt = 4'd0;
        cnt_nxt = 24'd0;
        if (len_r == 24'd0) begin
          tag.last = 1'b1;
        end else begin
          pay_nxt = 1'b1;
        end
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end else begin
      cnt_nxt = cnt_inc;
      if (cnt_inc >= len_r) begin
        tag.last = 1'b1;
        pay_nxt  = 1'b0;
        pos_nxt  = 4'd0;
      end
    end
    if (in_word.end_of_data && !tag.last) begin
      tag.trunc = 1'b1;
      pay_nxt   = 1'b0;
      pos_nxt   = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
      pay_r <= 1'b0;
      len_r <= 24'd0;
      cnt_r <= 24'd0;
    end else if (acc) begin
      pos_r <= pos_nxt;
      pay_r <= pay_nxt;
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/hfd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfd_queue
// Small register queue of tagged bytes between front and back.
// ----------------------------------------------------------------------------
module hfd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire hfd_pkg::hfd_tag_t wr_data,
  output logic                   q_full,
  input  wire logic              rd_en,
  output logic                   q_empty,
  output hfd_pkg::hfd_tag_t      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hfd_pkg::hfd_tag_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/hfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfd_back
// Assembles header fields, applies length and padding rules, drives result.
// ----------------------------------------------------------------------------
module hfd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire hfd_pkg::hfd_tag_t q_tag,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output hfd_pkg::hfd_out_t      out_word
);

  logic [23:0] len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [30:0] sid_r, sid_nxt;
  logic [1:0]  m3_r, m3_nxt;
  logic [23:0] lm1_r, lm1_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        ov_r, ov_nxt;
  hfd_pkg::hfd_out_t out_r, res;
  logic [7:0]  b;

  // residue mod 3 of a value up to 15
  function automatic logic [1:0] mod3_fold(input logic [3:0] s);
    logic [2:0] t;
    t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  function automatic logic [1:0] mod3_byte(input logic [7:0] v);
    logic [3:0] s;
    s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
    return mod3_fold(s);
  endfunction

  function automatic logic [1:0] mod3_add(input logic [1:0] r, input logic [7:0] v);
    return mod3_fold({2'b00, r} + {2'b00, mod3_byte(v)});
  endfunction

  function automatic logic pad_type(input logic [7:0] t);
    return (t == hfd_pkg::T_DATA) || (t == hfd_pkg::T_HEADERS) ||
           (t == hfd_pkg::T_PUSH);
  endfunction

  function automatic logic [2:0] rest_check(input logic [7:0] t, input logic [7:0] f,
                                            input logic [23:0] rest);
    if (t == hfd_pkg::T_HEADERS && f[hfd_pkg::F_PRIO_BIT] && rest < 24'd5) begin
      return hfd_pkg::V_SHORT;
    end
    if (t == hfd_pkg::T_PUSH && rest < 24'd4) begin
      return hfd_pkg::V_SHORT;
    end
    return hfd_pkg::V_OK;
  endfunction

  // m3 is the length mod 3; length is a multiple of 6 when even and m3 is 0
  function automatic logic [2:0] hdr_check(input logic [23:0] len, input logic [7:0] t,
                                           input logic [7:0] f, input logic [1:0] m3);
    logic bad;
    bad = 1'b0;
    unique case (t) inside
      hfd_pkg::T_SETTINGS: bad = f[hfd_pkg::F_ACK_BIT] ? (len != 24'd0)
                                                      : (len[0] || (m3 != 2'd0));
      hfd_pkg::T_PRIORITY: bad = (len != 24'd5);
      hfd_pkg::T_PING:     bad = (len != 24'd8);
      hfd_pkg::T_GOAWAY:   bad = (len < 24'd8);
      hfd_pkg::T_RST,
      hfd_pkg::T_WINUPD:   bad = (len != 24'd4);
      hfd_pkg::T_PUSH:     bad = (len < 24'd4);
      default:             bad = 1'b0;
    endcase
    if (bad) begin
      return hfd_pkg::V_LEN;
    end
    if (pad_type(t)) begin
      if (f[hfd_pkg::F_PADDED_BIT]) begin
        return (len == 24'd0) ? hfd_pkg::V_PAD : hfd_pkg::V_OK;
      end
      return rest_check(t, f, len);
    end
    return hfd_pkg::V_OK;
  endfunction

  assign q_pop    = !q_empty && (!ov_r || pop);
  assign empty    = !ov_r;
  assign out_word = out_r;
  assign b        = q_tag.data;

  always_comb begin
    len_nxt   = len_r;
    type_nxt  = type_r;
    flags_nxt = flags_r;
    sid_nxt   = sid_r;
    m3_nxt    = m3_r;
    lm1_nxt   = lm1_r;
    pend_nxt  = pend_r;
    if (!q_tag.payload) begin
      unique case (q_tag.hdr_pos)
        hfd_pkg::HP_LEN_HI: begin
          len_nxt   = {b, 16'h0000};
          type_nxt  = 8'h00;
          flags_nxt = 8'h00;
          sid_nxt   = 31'd0;
          m3_nxt    = mod3_byte(b);
          pend_nxt  = hfd_pkg::V_OK;
        end
        hfd_pkg::HP_LEN_MID: begin
          len_nxt[15:8] = b;
          m3_nxt        = mod3_add(m3_r, b);
        end
        hfd_pkg::HP_LEN_LO: begin
          len_nxt[7:0] = b;
          m3_nxt       = mod3_add(m3_r, b);
        end
        hfd_pkg::HP_TYPE:  type_nxt = b;
        hfd_pkg::HP_FLAGS: flags_nxt = b;
        hfd_pkg::HP_SID3:  sid_nxt = {b[6:0], 24'h000000};
        hfd_pkg::HP_SID2:  sid_nxt[23:16] = b;
        hfd_pkg::HP_SID1:  sid_nxt[15:8] = b;
        hfd_pkg::HP_LAST: begin
          sid_nxt[7:0] = b;
          pend_nxt     = hdr_check(len_r, type_r, flags_r, m3_r);
          lm1_nxt      = len_r - 24'd1;
        end
        default: ;
      endcase
    end else if (q_tag.first && pend_r == hfd_pkg::V_OK && pad_type(type_r) &&
                 flags_r[hfd_pkg::F_PADDED_BIT]) begin
      if ({16'h0000, b} > lm1_r) begin
        pend_nxt = hfd_pkg::V_PAD;
      end else begin
        pend_nxt = rest_check(type_r, flags_r, lm1_r - {16'h0000, b});
      end
    end

    res                = '0;
    res.out_byte       = b;
    res.payload_valid  = q_tag.payload;
    res.frame_done     = q_tag.last || q_tag.trunc;
    if (res.frame_done) begin
      res.frame_type     = type_nxt;
      res.frame_flags    = flags_nxt;
      res.stream_id      = sid_nxt;
      res.payload_length = len_nxt;
      res.verdict        = q_tag.trunc ? hfd_pkg::V_TRUNC : pend_nxt;
    end
    ov_nxt = q_pop || (ov_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= 24'd0;
      type_r  <= 8'h00;
      flags_r <= 8'h00;
      sid_r   <= 31'd0;
      m3_r    <= 2'd0;
      lm1_r   <= 24'd0;
      pend_r  <= hfd_pkg::V_OK;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (q_pop) begin
        len_r   <= len_nxt;
        type_r  <= type_nxt;
        flags_r <= flags_nxt;
        sid_r   <= sid_nxt;
        m3_r    <= m3_nxt;
        lm1_r   <= lm1_nxt;
        pend_r  <= pend_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/http2_frame_deframer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http2_frame_deframer_unit
// HTTP/2 frame deframer: one stream byte in, one result word out per byte.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            word
//   input    in         push / full          in_word  (in_byte, end_of_data)
//   result   out        empty / pop          out_word (byte, frame report)
//
// One byte per cycle while pop keeps up; result passes the queue, then out_r.
// The rate is set by the front's combinational position/count update.
// The queue holds QUEUE_DEPTH tagged bytes; the back output register adds one.
// Synchronous active-low reset clears all parser state; no clearing pass.
// A stalled output fills the queue, then full rises until pop resumes.
module http2_frame_deframer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire hfd_pkg::hfd_in_t in_word,
  output logic                  empty,
  input  wire logic             pop,
  output hfd_pkg::hfd_out_t     out_word
);

  hfd_pkg::hfd_tag_t f_tag, q_tag;
  logic acc, q_empty, q_pop;

  assign acc = push && !full;

  hfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_word (in_word),
    .tag     (f_tag)
  );

  hfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (acc),
    .wr_data (f_tag),
    .q_full  (full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_data (q_tag)
  );

  hfd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_tag    (q_tag),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

// File: sv/hfd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module hfd_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire hfd_pkg::hfd_out_t out_word
);

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_word.frame_done) |->
      (out_word.frame_type == 8'h00 && out_word.frame_flags == 8'h00 &&
       out_word.stream_id == 31'd0 && out_word.payload_length == 24'd0 &&
       out_word.verdict == hfd_pkg::V_OK))
    else $error("fields set on a word that ends no frame");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.frame_done) |-> (out_word.verdict <= hfd_pkg::V_TRUNC))
    else $error("verdict out of range");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (empty && !full))
    else $error("result present right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("stalled result word changed");

endmodule

bind http2_frame_deframer_unit hfd_checker u_hfd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_word (out_word)
);
`default_nettype wire
